// ===== rtl/core/rsra_pkg.sv =====
// Shared types and constants for the refcounted slot run allocator.
// No dependencies; imported by every module of the block but rsra_ram.
package rsra_pkg;

  // Default sizes for the top level parameters.
  localparam int SlotCountDef = 64;
  localparam int MaxRunDef    = 16;
  localparam int IdBitsDef    = 16;
  localparam int OwnerBitsDef = 8;

  // Command codes on cmd_i.
  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic scan_cmp;
    logic step_j;
    logic next_win;
    logic raise_init;
    logic app_init;
    logic raise_wr;
    logic finish_ok;
    logic finish_full;
    logic rel_sel;
    logic rel_wr;
    logic step_k;
  } rsra_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;
    logic acc_alloc;
    logic acc_rel;
    logic win_fits;
    logic app_fits;
    logic j_last;
    logic hit_now;
    logic k_last;
  } rsra_sts_t;

endpackage

// ===== rtl/core/rsra_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rsra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rsra_ctrl.sv =====
// Sequencer for the slot run allocator: clear pass, window scan, raise/append,
// release. Depends on rsra_pkg.
module rsra_ctrl import rsra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  rsra_sts_t sts_i,
  output rsra_cmd_t ctl_o,
  output logic      busy_o
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_WIN      = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CMP = 4'd4;
  localparam logic [3:0] S_APP      = 4'd5;
  localparam logic [3:0] S_RAISE_RD = 4'd6;
  localparam logic [3:0] S_RAISE_WR = 4'd7;
  localparam logic [3:0] S_REL_RD   = 4'd8;
  localparam logic [3:0] S_REL_WR   = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        ctl_o.clear_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl_o.accept = 1'b1;
          if (sts_i.acc_alloc) begin
            state_d = S_WIN;
          end else if (sts_i.acc_rel) begin
            state_d = S_REL_RD;
          end
        end
      end
      S_WIN: begin
        state_d = sts_i.win_fits ? S_SCAN_RD : S_APP;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        ctl_o.scan_cmp = 1'b1;
        if (!sts_i.j_last) begin
          ctl_o.step_j = 1'b1;
          state_d      = S_SCAN_RD;
        end else if (sts_i.hit_now) begin
          ctl_o.raise_init = 1'b1;
          state_d          = S_RAISE_RD;
        end else begin
          ctl_o.next_win = 1'b1;
          state_d        = S_WIN;
        end
      end
      S_APP: begin
        if (sts_i.app_fits) begin
          ctl_o.app_init = 1'b1;
          state_d        = S_RAISE_RD;
        end else begin
          ctl_o.finish_full = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_RAISE_RD: begin
        state_d = S_RAISE_WR;
      end
      S_RAISE_WR: begin
        ctl_o.raise_wr = 1'b1;
        if (sts_i.j_last) begin
          ctl_o.finish_ok = 1'b1;
          state_d         = S_IDLE;
        end else begin
          ctl_o.step_j = 1'b1;
          state_d      = S_RAISE_RD;
        end
      end
      S_REL_RD: begin
        ctl_o.rel_sel = 1'b1;
        state_d       = S_REL_WR;
      end
      S_REL_WR: begin
        ctl_o.rel_sel = 1'b1;
        ctl_o.rel_wr  = 1'b1;
        if (sts_i.k_last) begin
          state_d = S_IDLE;
        end else begin
          ctl_o.step_k = 1'b1;
          state_d      = S_REL_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/core/rsra_dp.sv =====
// Datapath of the slot run allocator: slot, owner and run RAMs, counters,
// result registers. Depends on rsra_pkg and rsra_ram.
module rsra_dp import rsra_pkg::*; #(
  parameter int SLOT_COUNT = SlotCountDef,
  parameter int MAX_RUN    = MaxRunDef,
  parameter int ID_BITS    = IdBitsDef,
  parameter int OWNER_BITS = OwnerBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_i,
  input  logic [15:0] image_id_i,
  input  logic        run_last_i,
  input  logic [5:0]  start_index_i,
  input  logic [6:0]  release_count_i,
  input  rsra_cmd_t   ctl_i,
  output rsra_sts_t   sts_o,
  output logic        done_o,
  output logic [5:0]  slot_index_o,
  output logic        full_res_o,
  output logic        needs_update_o
);

  localparam int SLOT_AW = $clog2(SLOT_COUNT);
  localparam int USED_W  = $clog2(SLOT_COUNT + 1);
  localparam int RUN_AW  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int RUN_CW  = $clog2(MAX_RUN + 1);
  localparam int SUM_W   = ((USED_W > RUN_CW) ? USED_W : RUN_CW) + 1;
  localparam logic [OWNER_BITS-1:0] OWN_MAX = {OWNER_BITS{1'b1}};

  logic [USED_W-1:0] base_q, base_d, used_q, used_d;
  logic [RUN_AW-1:0] j_q, j_d;
  logic [6:0]        k_q, k_d;
  logic [RUN_CW-1:0] run_len_q, run_len_d, n_q;
  logic              hit_q, hit_d, app_q, app_d, dirty_q, dirty_d;
  logic [5:0]        start_q;
  logic [6:0]        count_q;
  logic              done_q, full_q, upd_q;
  logic [5:0]        slot_q;

  logic [ID_BITS-1:0]    slot_rd, run_rd, id_in;
  logic [ID_BITS+15:0]   id_ext;
  logic [OWNER_BITS-1:0] own_rd, own_wdata;
  logic [SUM_W-1:0]      win_sum, win_end, app_end;
  logic [SLOT_AW-1:0]    slot_addr, rel_addr, own_waddr, own_raddr;
  logic [7:0]            rel_sum;
  logic [SLOT_AW+7:0]    rel_ext;
  logic [USED_W+5:0]     base_ext;
  logic                  rel_in, mismatch, own_zero, scan_wr, slot_we, own_we;
  logic                  is_add, room, run_we;
  logic [RUN_CW-1:0]     run_next;

  assign id_ext = {{ID_BITS{1'b0}}, image_id_i};
  assign id_in  = id_ext[ID_BITS-1:0];

  assign is_add   = (cmd_i == CMD_ADD);
  assign room     = (run_len_q < RUN_CW'(MAX_RUN));
  assign run_next = run_len_q + RUN_CW'(room);
  assign run_we   = ctl_i.accept & is_add & room;

  // Window and release addressing
  assign win_sum   = SUM_W'(base_q) + SUM_W'(j_q);
  assign slot_addr = win_sum[SLOT_AW-1:0];
  assign win_end   = SUM_W'(base_q) + SUM_W'(n_q);
  assign app_end   = SUM_W'(used_q) + SUM_W'(n_q);
  assign rel_sum   = {2'b00, start_q} + {1'b0, k_q};
  assign rel_ext   = {{SLOT_AW{1'b0}}, rel_sum};
  assign rel_addr  = rel_ext[SLOT_AW-1:0];
  assign rel_in    = ({24'd0, rel_sum} < 32'(SLOT_COUNT));

  assign mismatch = (slot_rd != run_rd);
  assign own_zero = (own_rd == '0);
  assign scan_wr  = ctl_i.scan_cmp & mismatch & own_zero;
  assign slot_we  = scan_wr | (ctl_i.raise_wr & app_q);

  assign own_we = ctl_i.clear_step | ctl_i.raise_wr | (ctl_i.rel_wr & rel_in & !own_zero);

  always_comb begin
    if (ctl_i.clear_step) begin
      own_waddr = base_q[SLOT_AW-1:0];
      own_wdata = '0;
    end else if (ctl_i.rel_wr) begin
      own_waddr = rel_addr;
      own_wdata = own_rd - OWNER_BITS'(1);
    end else begin
      own_waddr = slot_addr;
      own_wdata = (own_rd == OWN_MAX) ? own_rd : own_rd + OWNER_BITS'(1);
    end
  end

  assign own_raddr = ctl_i.rel_sel ? rel_addr : slot_addr;

  rsra_ram #(.WIDTH(ID_BITS), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_addr),
    .wdata_i(run_rd),
    .raddr_i(slot_addr),
    .rdata_o(slot_rd)
  );

  rsra_ram #(.WIDTH(OWNER_BITS), .DEPTH(SLOT_COUNT)) u_owner_ram (
    .clk_i  (clk_i),
    .we_i   (own_we),
    .waddr_i(own_waddr),
    .wdata_i(own_wdata),
    .raddr_i(own_raddr),
    .rdata_o(own_rd)
  );

  rsra_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_RUN)) u_run_ram (
    .clk_i  (clk_i),
    .we_i   (run_we),
    .waddr_i(run_len_q[RUN_AW-1:0]),
    .wdata_i(id_in),
    .raddr_i(j_q),
    .rdata_o(run_rd)
  );

  // Next-state of counters and flags
  always_comb begin
    base_d    = base_q;
    j_d       = j_q;
    k_d       = k_q;
    hit_d     = hit_q;
    app_d     = app_q;
    used_d    = used_q;
    run_len_d = run_len_q;
    dirty_d   = dirty_q | slot_we;

    if (ctl_i.clear_step || ctl_i.next_win) begin
      base_d = base_q + USED_W'(1);
    end else if (ctl_i.accept) begin
      base_d = '0;
    end else if (ctl_i.app_init) begin
      base_d = used_q;
    end

    if (ctl_i.accept || ctl_i.next_win || ctl_i.raise_init || ctl_i.app_init) begin
      j_d = '0;
    end else if (ctl_i.step_j) begin
      j_d = j_q + RUN_AW'(1);
    end

    if (ctl_i.accept) begin
      k_d = '0;
    end else if (ctl_i.step_k) begin
      k_d = k_q + 7'd1;
    end

    if (ctl_i.accept || ctl_i.next_win) begin
      hit_d = 1'b1;
    end else if (ctl_i.scan_cmp) begin
      hit_d = sts_o.hit_now;
    end

    if (ctl_i.accept) begin
      app_d = 1'b0;
    end else if (ctl_i.app_init) begin
      app_d = 1'b1;
    end

    if (ctl_i.finish_ok && app_q) begin
      used_d = app_end[USED_W-1:0];
    end

    if (ctl_i.accept && is_add) begin
      run_len_d = run_last_i ? '0 : run_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      j_q       <= '0;
      k_q       <= '0;
      hit_q     <= 1'b0;
      app_q     <= 1'b0;
      used_q    <= '0;
      run_len_q <= '0;
      dirty_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      base_q    <= base_d;
      j_q       <= j_d;
      k_q       <= k_d;
      hit_q     <= hit_d;
      app_q     <= app_d;
      used_q    <= used_d;
      run_len_q <= run_len_d;
      dirty_q   <= dirty_d;
      done_q    <= ctl_i.finish_ok | ctl_i.finish_full;
    end
  end

  assign base_ext = {6'd0, base_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      n_q     <= run_next;
      start_q <= start_index_i;
      count_q <= release_count_i;
    end
    if (ctl_i.finish_ok || ctl_i.finish_full) begin
      slot_q <= ctl_i.finish_ok ? base_ext[5:0] : 6'd0;
      full_q <= ctl_i.finish_full;
      upd_q  <= dirty_d;
    end
  end

  assign sts_o.clr_last  = (base_q == USED_W'(SLOT_COUNT - 1));
  assign sts_o.acc_alloc = is_add & run_last_i;
  assign sts_o.acc_rel   = !is_add & (release_count_i != 7'd0);
  assign sts_o.win_fits  = (win_end <= SUM_W'(used_q));
  assign sts_o.app_fits  = (app_end <= SUM_W'(SLOT_COUNT));
  assign sts_o.j_last    = ((RUN_CW'(j_q) + RUN_CW'(1)) == n_q);
  assign sts_o.hit_now   = hit_q & !(mismatch & !own_zero);
  assign sts_o.k_last    = ((k_q + 7'd1) == count_q);

  assign done_o         = done_q;
  assign slot_index_o   = slot_q;
  assign full_res_o     = full_q;
  assign needs_update_o = upd_q;

endmodule

// ===== rtl/core/refcounted_slot_run_allocator_core.sv =====
// Top level of the refcounted slot run allocator.
// Depends on rsra_pkg, rsra_ctrl, rsra_dp (which holds the rsra_ram instances).

// A command beat is taken when start is high and busy is low; results come
// back on done_o for exactly one cycle and cannot be held off. After reset the
// block runs a clearing pass over the owner count RAM and keeps busy high
// until every owner count is cleared. An add beat without run_last leaves
// busy low, and the next beat may follow at once. A release of c slots takes
// one RAM read and one write per slot after the accept; a count of zero ends
// with the accept. An allocation of a run of n IDs tries windows in turn: a
// window test, then per slot of the window a read step and a compare/write
// step (owner and slot RAMs are single-read). When no window hits, the append
// check follows (the window test that no longer fits and the capacity test).
// A hit or an append then raises the owner counts, with a read and a write
// step per slot (and writes the IDs on an append). With u used slots, up to
// u - n + 1 windows are tried. The result beat appears on done_o in the cycle
// after the last work cycle, and busy is already low in that cycle.
module refcounted_slot_run_allocator_core import rsra_pkg::*; #(
  parameter int SLOT_COUNT = SlotCountDef,
  parameter int MAX_RUN    = MaxRunDef,
  parameter int ID_BITS    = IdBitsDef,
  parameter int OWNER_BITS = OwnerBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [15:0] image_id_i,
  input  logic        run_last_i,
  input  logic [5:0]  start_index_i,
  input  logic [6:0]  release_count_i,
  output logic        done_o,
  output logic [5:0]  slot_index_o,
  output logic        full_res_o,
  output logic        needs_update_o
);

  rsra_cmd_t ctl;
  rsra_sts_t sts;

  // Sequencer: owns all state transitions, no payload.
  rsra_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .sts_i (sts),
    .ctl_o (ctl),
    .busy_o(busy)
  );

  // Datapath: tables, window/run counters, result registers.
  rsra_dp #(
    .SLOT_COUNT(SLOT_COUNT),
    .MAX_RUN   (MAX_RUN),
    .ID_BITS   (ID_BITS),
    .OWNER_BITS(OWNER_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .image_id_i     (image_id_i),
    .run_last_i     (run_last_i),
    .start_index_i  (start_index_i),
    .release_count_i(release_count_i),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .done_o         (done_o),
    .slot_index_o   (slot_index_o),
    .full_res_o     (full_res_o),
    .needs_update_o (needs_update_o)
  );

endmodule

// ===== rtl/core/rsra_checker.sv =====
// Port-level checks for refcounted_slot_run_allocator_core, with bind.
// Depends on rsra_pkg for command codes.
module rsra_checker import rsra_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       cmd_i,
  input logic       run_last_i,
  input logic       done_o,
  input logic [5:0] slot_index_o,
  input logic       full_res_o
);

  // A result beat only closes a busy period.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without preceding work");

  // The block is idle again while it shows a result.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy during result beat");

  // Release and non-final add beats never produce a result.
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == CMD_RELEASE || !run_last_i)) |=> !done_o)
    else $error("result after a beat that takes none");

  // A final add beat starts an allocation.
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_ADD && run_last_i) |=> busy)
    else $error("allocation did not start");

  // A full result carries slot 0.
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && full_res_o) |-> (slot_index_o == 6'd0))
    else $error("full result with nonzero slot");

endmodule

bind refcounted_slot_run_allocator_core rsra_checker u_rsra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .cmd_i       (cmd_i),
  .run_last_i  (run_last_i),
  .done_o      (done_o),
  .slot_index_o(slot_index_o),
  .full_res_o  (full_res_o)
);

// ===== test/refcounted_slot_run_allocator_core_tb.sv =====
// Self-checking testbench for refcounted_slot_run_allocator_core.
// Uses rsra_pkg for sizes and command codes; the bench holds its own
// copy of the slot table and its checker compares each result beat in order.
module refcounted_slot_run_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsra_pkg::*;

  localparam int          CLK_PERIOD  = 10;
  localparam int          TOTAL_BEATS = 1450;
  localparam int          CALM_BEATS  = 150;   // final stretch with no sender gaps
  localparam int          SAT_AT      = 600;   // where the hot-slot burst starts
  localparam int          SAT_BURST   = 270;   // more hits than one count can hold
  localparam int          TAIL_CYCLES = 300;   // covers a trailing 64-slot release
  localparam logic [7:0]  OWN_TOP     = 8'((1 << OwnerBitsDef) - 1);
  // Slowest allocation: 49 windows of a 16-ID run, then the raise. Even with
  // every beat that slow the run stays far below this.
  localparam int unsigned CYCLE_LIMIT = 12_000_000;

  typedef struct {
    logic [5:0] idx;
    logic       full;
    logic       upd;
  } alloc_res_t;

  typedef struct {
    logic       cmd;
    logic [15:0] id;
    logic       lst;
    logic [5:0] si;
    logic [6:0] rc;
    bit         typed;   // expected result typed in by hand
    alloc_res_t res;
  } stim_row_t;

  // Clock, reset and driven inputs, all known from time zero.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start         = 1'b0;
  logic        cmd           = CMD_ADD;
  logic [15:0] image_id      = '0;
  logic        run_last      = 1'b0;
  logic [5:0]  start_index   = '0;
  logic [6:0]  release_count = '0;

  logic       busy;
  logic       done_o;
  logic [5:0] slot_index_o;
  logic       full_res_o;
  logic       needs_update_o;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  refcounted_slot_run_allocator_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd),
    .image_id_i     (image_id),
    .run_last_i     (run_last),
    .start_index_i  (start_index),
    .release_count_i(release_count),
    .done_o         (done_o),
    .slot_index_o   (slot_index_o),
    .full_res_o     (full_res_o),
    .needs_update_o (needs_update_o)
  );

  // ---------------------------------------------------------------------
  // Shadow of the block: slot table, owner counts, gathered run, dirty flag.
  // ---------------------------------------------------------------------
  logic [15:0] slot_id_m [SlotCountDef];
  logic [7:0]  owner_m   [SlotCountDef];
  int          used_m    = 0;
  logic [15:0] run_m     [MaxRunDef];
  int          run_len_m = 0;
  bit          over_m    = 1'b0;
  bit          dirty_m   = 1'b0;

  alloc_res_t  pending_allocs [$];   // results owed by the block, oldest first
  alloc_res_t  no_res;

  int unsigned cycles    = 0;
  int          beats     = 0;
  int          idle_pct  = 0;
  int          n_fail    = 0;
  int          n_results = 0;
  int          n_rel     = 0;
  int          n_allocs  = 0;
  int          n_hit     = 0;
  int          n_full    = 0;
  int          n_over    = 0;
  int          n_sat     = 0;

  function automatic void note_fail(string msg);
    n_fail++;
    if (n_fail <= 10) $display("MISMATCH: %s", msg);
  endfunction

  // Owner counts stick at the top instead of wrapping.
  function automatic void raise_window(int first, int n);
    for (int j = 0; j < n; j++) begin
      if (owner_m[first + j] != OWN_TOP) owner_m[first + j]++;
      else n_sat++;
    end
  endfunction

  // Applies one accepted beat to the shadow; has is set when a result is owed.
  function automatic void apply_beat(input logic c, input logic [15:0] id,
                                     input logic lst, input logic [5:0] si,
                                     input logic [6:0] rc, output bit has,
                                     output alloc_res_t r);
    int n;
    int s;
    int where;
    bit hit;
    bit placed;
    has = 1'b0;
    r = no_res;
    if (c == CMD_RELEASE) begin
      n_rel++;
      for (int k = 0; k < rc; k++) begin
        s = si + k;
        if (s < SlotCountDef && owner_m[s] != 0) owner_m[s]--;
      end
      return;
    end
    // IDs past MAX_RUN are dropped, the closing one included.
    if (run_len_m < MaxRunDef) begin
      run_m[run_len_m] = id;
      run_len_m++;
    end else begin
      over_m = 1'b1;
    end
    if (!lst) return;

    n = run_len_m;
    placed = 1'b0;
    where = 0;
    if (n <= used_m) begin
      for (int i = 0; i + n <= used_m && !placed; i++) begin
        hit = 1'b1;
        for (int j = 0; j < n; j++) begin
          s = i + j;
          if (slot_id_m[s] != run_m[j]) begin
            // free slots get rewritten even when the window later fails
            if (owner_m[s] == 0) begin
              slot_id_m[s] = run_m[j];
              dirty_m = 1'b1;
            end else begin
              hit = 1'b0;
            end
          end
        end
        if (hit) begin
          raise_window(i, n);
          where = i;
          placed = 1'b1;
          n_hit++;
        end
      end
    end
    if (!placed && used_m + n <= SlotCountDef) begin
      for (int j = 0; j < n; j++) slot_id_m[used_m + j] = run_m[j];
      dirty_m = 1'b1;
      raise_window(used_m, n);
      where = used_m;
      used_m += n;
      placed = 1'b1;
    end
    if (!placed) n_full++;
    if (over_m) n_over++;
    n_allocs++;
    run_len_m = 0;
    over_m = 1'b0;
    has = 1'b1;
    r.idx = placed ? where[5:0] : 6'd0;
    r.full = !placed;
    r.upd = dirty_m;
  endfunction

  // Presents one beat, holds it until taken, then books the owed result.
  // start stays high when the next beat follows directly.
  task automatic send_beat(input logic c, input logic [15:0] id, input logic lst,
                           input logic [5:0] si, input logic [6:0] rc,
                           input bit typed, input alloc_res_t typed_res);
    bit has;
    alloc_res_t r;
    start <= 1'b1;
    cmd <= c;
    image_id <= id;
    run_last <= lst;
    start_index <= si;
    release_count <= rc;
    do @(posedge clk_i); while (busy !== 1'b0);
    apply_beat(c, id, lst, si, rc, has, r);
    if (has) pending_allocs.push_back(typed ? typed_res : r);
    beats++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic send_release();
    int pick;
    logic [6:0] rc;
    pick = $urandom_range(0, 9);
    if (pick == 0) rc = 7'd0;
    else if (pick == 1) rc = 7'd64;
    else if (pick < 7) rc = 7'($urandom_range(1, 8));
    else rc = 7'($urandom_range(0, 64));
    send_beat(CMD_RELEASE, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
              6'($urandom_range(0, 63)), rc, 1'b0, no_res);
  endtask

  // Mostly a small pool so runs recur and windows hit; the rest fully random.
  function automatic logic [15:0] next_id();
    if ($urandom_range(0, 9) < 6) return 16'h5A00 | 16'($urandom_range(0, 7));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_allocs.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Result checker: every done_o beat must match the oldest owed result.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    alloc_res_t e;
    if (rst_ni && done_o === 1'b1) begin
      n_results++;
      if (pending_allocs.size() == 0) begin
        note_fail($sformatf("unexpected result idx %0d full %b upd %b",
                            slot_index_o, full_res_o, needs_update_o));
      end else begin
        e = pending_allocs.pop_front();
        if (slot_index_o !== e.idx || full_res_o !== e.full || needs_update_o !== e.upd)
          note_fail($sformatf("result %0d: expected idx %0d full %b upd %b, got idx %0d full %b upd %b",
                              n_results, e.idx, e.full, e.upd,
                              slot_index_o, full_res_o, needs_update_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed table first, then random runs and releases.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t rows [$];
    stim_row_t row;
    int len;
    int pick;
    int base;
    bit replay;
    bit sat_done;
    logic [15:0] id;

    no_res = '{idx: 6'd0, full: 1'b0, upd: 1'b0};
    for (int s = 0; s < SlotCountDef; s++) begin
      slot_id_m[s] = '0;
      owner_m[s] = '0;
    end
    for (int j = 0; j < MaxRunDef; j++) run_m[j] = '0;
    sat_done = 1'b0;

    // All-ones ID into an empty table lands at slot 0.
    rows.push_back('{CMD_ADD, 16'hFFFF, 1'b1, 6'd0, 7'd0, 1'b1, '{6'd0, 1'b0, 1'b1}});
    // All-zeros ID: slot 0 is owned and differs, so it is appended at 1.
    rows.push_back('{CMD_ADD, 16'h0000, 1'b1, 6'd63, 7'd64, 1'b1, '{6'd1, 1'b0, 1'b1}});
    // Same all-ones ID again hits the first window.
    rows.push_back('{CMD_ADD, 16'hFFFF, 1'b1, 6'd0, 7'd0, 1'b1, '{6'd0, 1'b0, 1'b1}});
    // Two-ID run that matches no window, appended.
    rows.push_back('{CMD_ADD, 16'h0000, 1'b0, 6'd0, 7'd0, 1'b0, no_res});
    rows.push_back('{CMD_ADD, 16'hFFFF, 1'b1, 6'd0, 7'd0, 1'b0, no_res});
    // Releases: whole table, range running off the end, empty range.
    rows.push_back('{CMD_RELEASE, 16'h0000, 1'b0, 6'd0, 7'd64, 1'b0, no_res});
    rows.push_back('{CMD_RELEASE, 16'hFFFF, 1'b1, 6'd63, 7'd64, 1'b0, no_res});
    rows.push_back('{CMD_RELEASE, 16'h1234, 1'b0, 6'd5, 7'd0, 1'b0, no_res});
    // Over-long run: 17 IDs, the closing one is dropped but ends the run.
    for (int e = 0; e <= MaxRunDef; e++) begin
      row = '{CMD_ADD, 16'(e * 16'h0F0F) ^ 16'hA5C3, e == MaxRunDef, 6'd0, 7'd0,
              1'b0, no_res};
      rows.push_back(row);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats go back to back; the clearing pass holds them off first.
    foreach (rows[i])
      send_beat(rows[i].cmd, rows[i].id, rows[i].lst, rows[i].si, rows[i].rc,
                rows[i].typed, rows[i].res);
    wait_drained();

    while (beats < TOTAL_BEATS) begin
      if (beats >= TOTAL_BEATS - CALM_BEATS) idle_pct = 0;
      else if ($urandom_range(0, 3) == 0) idle_pct = 0;
      else idle_pct = 20;

      if (!sat_done && beats >= SAT_AT && used_m > 0) begin
        // Sender goes quiet until the block has answered everything, then
        // hammers slot 0 until its owner count pins at the top.
        wait_drained();
        repeat (SAT_BURST)
          send_beat(CMD_ADD, slot_id_m[0], 1'b1, 6'($urandom_range(0, 63)),
                    7'($urandom_range(0, 64)), 1'b0, no_res);
        sat_done = 1'b1;
      end else if ($urandom_range(0, 99) < 15) begin
        send_release();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(1, 4);
        else if (pick < 90) len = $urandom_range(5, MaxRunDef);
        else len = $urandom_range(MaxRunDef + 1, MaxRunDef + 4);
        // Replaying what is already in the table is what makes windows hit.
        replay = len <= used_m && $urandom_range(0, 1) == 1;
        base = replay ? $urandom_range(0, used_m - len) : 0;
        for (int e = 0; e < len; e++) begin
          if ($urandom_range(0, 19) == 0) send_release();
          id = replay ? slot_id_m[base + e] : next_id();
          send_beat(CMD_ADD, id, e == len - 1, 6'($urandom_range(0, 63)),
                    7'($urandom_range(0, 64)), 1'b0, no_res);
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d beats: %0d releases, %0d allocations (%0d window hits, %0d full).",
             beats, n_rel, n_allocs, n_hit, n_full);
    $display("Over-long runs: %0d, raises stopped at the count limit: %0d, slots used: %0d.",
             n_over, n_sat, used_m);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", n_fail);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
